>>> hdl/htd_pkg.sv
// Shared types and constants for the Huffman table decoder.
`timescale 1ns / 1ps

package htd_pkg;

    localparam int MAX_CODE_BITS_DEF = 16;
    localparam int BUF_BITS          = 24;
    localparam int HELD_BITS         = 5;
    localparam int FILL_LIMIT        = 16;
    localparam int MAX_RESULTS       = 24;
    localparam int COUNT_BITS        = 5;
    localparam int SYM_BITS          = 8;
    localparam int LEN_BITS          = 5;
    localparam int ENTRY_BITS        = SYM_BITS + LEN_BITS;
    localparam int IN_TDATA_BITS     = 40;
    localparam int OUT_TDATA_BITS    = 8;
    localparam int PADDR_BITS        = 3;

    localparam logic       OP_LOAD   = 1'b0;
    localparam logic       OP_STREAM = 1'b1;

    localparam logic [PADDR_BITS-1:0] ADDR_SYMBOL_COUNT = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DECODE
    } htd_state_t;

endpackage

>>> hdl/huffman_table_decoder.sv
// Top level: LSB-first Huffman decoder on a fully expanded lookup table.
`timescale 1ns / 1ps
//
// Channel   Dir   Beat contents
// s_axis    in    tuser=operation, tdata=symbol/length/code/byte, tlast=stream_last
// m_axis    out   tdata=symbol, tlast=run_last, tuser=done_res
// apb       in    register 0 at byte address 0: symbol_count
//
// A load beat fills each table slot whose low len bits equal its code, one table
// slot per cycle through the single write port. A stream beat decodes with one table
// lookup per cycle, one lookup per emitted symbol, until no further symbol is due.
// The table is not cleared at reset; only slots written by loads may be looked up.
// A stall on m_axis holds the decode loop; s_axis is taken only between items.

module huffman_table_decoder #(
    parameter int MAX_CODE_BITS = htd_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // [7:0] entry_symbol, [11:8] entry_length, [27:12] entry_code,
    // [35:28] stream_byte, [39:36] zero
    input  logic [htd_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    // [0] operation
    input  logic                                  s_axis_tuser,
    input  logic                                  s_axis_tlast,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] symbol
    output logic [htd_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    // [0] done_res
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [htd_pkg::PADDR_BITS-1:0]        paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    import htd_pkg::*;

    localparam int TABLE_DEPTH = 1 << MAX_CODE_BITS;

    // input field views
    logic [SYM_BITS-1:0] in_sym;
    logic [3:0]          in_len_field;
    logic [15:0]         in_code;
    logic [7:0]          in_byte;
    logic [LEN_BITS-1:0] in_len;
    logic [15:0]         in_code_masked;
    logic                in_accept;
    logic                load_ok;

    assign in_sym         = s_axis_tdata[7:0];
    assign in_len_field   = s_axis_tdata[11:8];
    assign in_code        = s_axis_tdata[27:12];
    assign in_byte        = s_axis_tdata[35:28];
    assign in_len         = (in_len_field == 4'd0) ? LEN_BITS'(16) : {1'b0, in_len_field};
    assign in_code_masked = in_code & ~(16'hFFFF << in_len);
    assign in_accept      = s_axis_tvalid && s_axis_tready;
    assign load_ok        = (in_len <= LEN_BITS'(MAX_CODE_BITS));

    // state
    htd_state_t                 state_reg, state_next;
    logic [BUF_BITS-1:0]        buf_reg, buf_next;
    logic [HELD_BITS-1:0]       held_reg, held_next;
    logic [31:0]                left_reg, left_next;
    logic [31:0]                count_reg, count_next;
    logic [COUNT_BITS-1:0]      n_reg, n_next;
    logic                       last_reg, last_next;
    logic [MAX_CODE_BITS-1:0]   ld_addr_reg, ld_addr_next;
    logic [SYM_BITS-1:0]        ld_sym_reg, ld_sym_next;
    logic [LEN_BITS-1:0]        ld_len_reg, ld_len_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SYM_BITS-1:0]        out_sym_reg, out_sym_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_done_reg, out_done_next;

    // decode table, 8-bit symbol with 5-bit length above it
    logic [ENTRY_BITS-1:0] table_mem [TABLE_DEPTH];
    logic [ENTRY_BITS-1:0] rd_data_reg;

    // control decoded from state
    logic in_ready;
    logic table_we;
    logic decoding;

    // datapath
    logic [MAX_CODE_BITS:0]  ld_sum;
    logic                    ld_wrap;
    logic [LEN_BITS-1:0]     rd_len;
    logic [SYM_BITS-1:0]     rd_sym;
    logic                    cond_now;
    logic                    cond_after;
    logic                    out_free;
    logic                    emit;
    logic                    finish;
    logic [BUF_BITS-1:0]     buf_after;
    logic [HELD_BITS-1:0]    held_after;
    logic [31:0]             left_after;
    logic [COUNT_BITS-1:0]   n_after;
    logic                    cfg_sel;
    logic                    cfg_wr;

    function automatic logic more_to_do(
        input logic [COUNT_BITS-1:0] n,
        input logic [31:0]           left,
        input logic [HELD_BITS-1:0]  held,
        input logic                  last
    );
        more_to_do = (n < COUNT_BITS'(MAX_RESULTS)) && (left != 32'd0) &&
                     ((held >= HELD_BITS'(MAX_CODE_BITS)) ||
                      (last && (held != HELD_BITS'(0))));
    endfunction

    assign rd_len   = rd_data_reg[ENTRY_BITS-1:SYM_BITS];
    assign rd_sym   = rd_data_reg[SYM_BITS-1:0];
    assign cond_now = more_to_do(n_reg, left_reg, held_reg, last_reg);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign emit     = decoding && cond_now && out_free;
    assign finish   = decoding && !cond_now;
    // register select on the word index; byte lanes inside a word are ignored
    assign cfg_sel  = (paddr[PADDR_BITS-1:2] == ADDR_SYMBOL_COUNT[PADDR_BITS-1:2]);
    assign cfg_wr   = psel && penable && pwrite && pready && cfg_sel;

    // slot sweep: step by 2^len until the address wraps
    assign ld_sum  = {1'b0, ld_addr_reg} + ((MAX_CODE_BITS + 1)'(1) << ld_len_reg);
    assign ld_wrap = ld_sum[MAX_CODE_BITS];

    always_comb
    begin
        if (rd_len >= held_reg)
        begin
            buf_after  = '0;
            held_after = '0;
        end
        else
        begin
            buf_after  = buf_reg >> rd_len;
            held_after = held_reg - rd_len;
        end
        left_after = left_reg - 32'd1;
        n_after    = n_reg + COUNT_BITS'(1);
        cond_after = more_to_do(n_after, left_after, held_after, last_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == OP_STREAM)
                        state_next = ST_DECODE;
                    else if (load_ok)
                        state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (ld_wrap)
                    state_next = ST_IDLE;
            end
            ST_DECODE:
            begin
                if (!cond_now)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        table_we = 1'b0;
        decoding = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_LOAD:   table_we = 1'b1;
            ST_DECODE: decoding = 1'b1;
            default:   in_ready = 1'b0;
        endcase
    end

    // register next values
    always_comb
    begin
        buf_next       = buf_reg;
        held_next      = held_reg;
        left_next      = left_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        last_next      = last_reg;
        ld_addr_next   = ld_addr_reg;
        ld_sym_next    = ld_sym_reg;
        ld_len_next    = ld_len_reg;
        out_sym_next   = out_sym_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        if (in_accept)
        begin
            if (s_axis_tuser == OP_STREAM)
            begin
                // a byte arriving with more than 16 bits held is dropped
                if (held_reg <= HELD_BITS'(FILL_LIMIT))
                begin
                    buf_next  = buf_reg | (BUF_BITS'(in_byte) << held_reg);
                    held_next = held_reg + HELD_BITS'(8);
                end
                last_next = s_axis_tlast;
                n_next    = '0;
            end
            else
            begin
                ld_addr_next = in_code_masked[MAX_CODE_BITS-1:0];
                ld_sym_next  = in_sym;
                ld_len_next  = in_len;
            end
        end

        if (table_we)
            ld_addr_next = ld_sum[MAX_CODE_BITS-1:0];

        if (emit)
        begin
            buf_next       = buf_after;
            held_next      = held_after;
            left_next      = left_after;
            n_next         = n_after;
            out_valid_next = 1'b1;
            out_sym_next   = rd_sym;
            out_last_next  = !cond_after;
            out_done_next  = (left_after == 32'd0);
        end

        // end of stream drops the padding bits
        if (finish && last_reg)
        begin
            buf_next  = '0;
            held_next = '0;
        end

        if (cfg_wr)
        begin
            count_next = pwdata;
            left_next  = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            buf_reg       <= '0;
            held_reg      <= '0;
            left_reg      <= '0;
            count_reg     <= '0;
            n_reg         <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_reg       <= buf_next;
            held_reg      <= held_next;
            left_reg      <= left_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_addr_reg  <= ld_addr_next;
        ld_sym_reg   <= ld_sym_next;
        ld_len_reg   <= ld_len_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    // table: one write port for the sweep, one registered read port that looks up
    // the slot for the next buffer contents; loads and decodes never overlap
    always_ff @(posedge clk)
    begin
        if (table_we)
            table_mem[ld_addr_reg] <= {ld_len_reg, ld_sym_reg};
        rd_data_reg <= table_mem[buf_next[MAX_CODE_BITS-1:0]];
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sym_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;
    assign pready        = 1'b1;
    assign prdata        = cfg_sel ? count_reg : 32'd0;

    // checks
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_BITS'(BUF_BITS))
        else $error("bit buffer holds more bits than it has");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= COUNT_BITS'(MAX_RESULTS))
        else $error("more results than the per-item cap");

    a_emit_owed: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (left_reg != 32'd0) && out_free)
        else $error("symbol emitted with none owed or output busy");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && last_reg) |=> (held_reg == '0))
        else $error("buffer not emptied after final byte");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && !ld_wrap) |=> !s_axis_tready)
        else $error("input taken during table sweep");

endmodule
